[rtl/core/mfcb_pkg.sv]
// Package for the multi-frame capture buffer: command and result beat types,
// item and error codes, and sizing constants. No dependencies.
package mfcb_pkg;

	// Default store depth in words.
	localparam int BUFFER_WORDS_DEF = 1024;

	// Fixed field widths.
	localparam int WORD_W    = 16;
	localparam int RADDR_W   = 10;
	localparam int FRAMES_W  = 8;
	localparam int PUBW_W    = 11;
	localparam int BATCH_W   = 16;
	// Wide enough for offset + 1 + length and for depth compares without wrap.
	localparam int SUM_W     = 18;

	// Batch size after reset.
	localparam logic [FRAMES_W-1:0] FPB_RESET = 8'd4;

	// Item codes.
	localparam logic [1:0] FUNC_BEGIN = 2'd0;
	localparam logic [1:0] FUNC_DATA  = 2'd1;
	localparam logic [1:0] FUNC_ACK   = 2'd2;
	localparam logic [1:0] FUNC_READ  = 2'd3;

	// Error codes.
	localparam logic [2:0] ERR_NONE   = 3'd0;
	localparam logic [2:0] ERR_FROZEN = 3'd1;
	localparam logic [2:0] ERR_EMPTY  = 3'd2;
	localparam logic [2:0] ERR_NOROOM = 3'd3;
	localparam logic [2:0] ERR_UNEXP  = 3'd4;

	typedef struct packed {
		logic [1:0]         func;
		logic [WORD_W-1:0]  word;
		logic [RADDR_W-1:0] read_addr;
	} cmd_t;

	typedef struct packed {
		logic                accepted;
		logic [2:0]          error_code;
		logic [WORD_W-1:0]   read_data;
		logic                ready_res;
		logic                collecting;
		logic [FRAMES_W-1:0] frames_published;
		logic [PUBW_W-1:0]   words_published;
		logic [BATCH_W-1:0]  batch_id;
	} res_t;

endpackage

[rtl/core/multi_frame_capture_buffer.sv]
// Top level of the multi-frame capture buffer: frame store, batch control
// and result register. Depends on mfcb_pkg.
//
//  channel   | direction | handshake                  | beat
//  ----------+-----------+----------------------------+------------------------
//  command   | in        | start high while busy low  | cmd (func, word, addr)
//  result    | out       | done strobe, one cycle     | res (status and counts)
//  config    | in        | cfg_valid and cfg_ready    | cfg_data (batch size)
//
// Every command beat takes one cycle: the result appears on the cycle after
// the command is taken, and a new command may be taken in that same cycle.
// The figure is set by the one-cycle read latency of the frame store.
// busy is high only while a configuration beat is being written.
// Reset clears all control state; the frame store itself is not cleared, and
// words that were never written read back as whatever the memory holds.
// The receiver cannot stall: each result is shown for exactly one cycle.
module multi_frame_capture_buffer
	import mfcb_pkg::*;
#(
	parameter int BUFFER_WORDS = BUFFER_WORDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  cmd_t                cmd,
	output logic                done,
	output res_t                res,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [FRAMES_W-1:0] cfg_data
);

	// Offset must hold the depth itself; address only indexes it.
	localparam int OFF_W = $clog2(BUFFER_WORDS + 1);
	localparam int AW    = $clog2(BUFFER_WORDS);

	// Frame store: one write port, one registered read port.
	logic [WORD_W-1:0] mem [BUFFER_WORDS];
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [WORD_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [WORD_W-1:0] rdata_s1;

	// Batch state.
	logic [OFF_W-1:0]    off_q, off_d;
	logic [FRAMES_W-1:0] fs_q, fs_d;
	logic [OFF_W-1:0]    rem_q, rem_d;
	logic                recv_q, recv_d;
	logic                ready_q, ready_d;
	logic                coll_q, coll_d;
	logic [FRAMES_W-1:0] pubf_q, pubf_d;
	logic [PUBW_W-1:0]   pubw_q, pubw_d;
	logic [BATCH_W-1:0]  batch_q, batch_d;
	logic [FRAMES_W-1:0] fpb_q;

	// Result register; read data joins it from the store's output register.
	logic       done_q;
	logic       acc_q, acc_d;
	logic [2:0] err_q, err_d;
	logic       rdsel_q, rdsel_d;

	logic                accept;
	logic [OFF_W-1:0]    off_inc;
	logic [OFF_W-1:0]    rem_dec;
	logic [FRAMES_W-1:0] fs_inc;
	logic [SUM_W-1:0]    fit_sum;
	logic                addr_ok;

	// A configuration beat takes the cycle; commands wait behind it.
	assign cfg_ready = 1'b1;
	assign busy      = cfg_valid;
	assign accept    = start && !busy;

	assign off_inc = off_q + OFF_W'(1);
	assign rem_dec = rem_q - OFF_W'(1);
	assign fs_inc  = fs_q + FRAMES_W'(1);
	assign fit_sum = SUM_W'(off_q) + SUM_W'(1) + SUM_W'(cmd.word);
	assign addr_ok = SUM_W'(cmd.read_addr) < SUM_W'(BUFFER_WORDS);

	always_comb begin
		off_d     = off_q;
		fs_d      = fs_q;
		rem_d     = rem_q;
		recv_d    = recv_q;
		ready_d   = ready_q;
		coll_d    = coll_q;
		pubf_d    = pubf_q;
		pubw_d    = pubw_q;
		batch_d   = batch_q;
		acc_d     = 1'b0;
		err_d     = ERR_NONE;
		rdsel_d   = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = off_q[AW-1:0];
		mem_wdata = cmd.word;
		mem_re    = 1'b0;
		mem_raddr = AW'(cmd.read_addr);
		if (accept) begin
			case (cmd.func)
				FUNC_BEGIN: begin
					if (ready_q) begin
						err_d = ERR_FROZEN;
					end else if (recv_q) begin
						err_d = ERR_UNEXP;
					end else if (cmd.word == '0) begin
						err_d = ERR_EMPTY;
					end else if (fit_sum > SUM_W'(BUFFER_WORDS)) begin
						err_d = ERR_NOROOM;
					end else begin
						if (fs_q == '0) begin
							coll_d = 1'b1;
						end
						// The fit check keeps the length below the depth.
						mem_we = 1'b1;
						off_d  = off_inc;
						rem_d  = OFF_W'(cmd.word);
						recv_d = 1'b1;
						acc_d  = 1'b1;
					end
				end
				FUNC_DATA: begin
					if (!recv_q) begin
						err_d = ready_q ? ERR_FROZEN : ERR_UNEXP;
					end else begin
						mem_we = 1'b1;
						off_d  = off_inc;
						rem_d  = rem_dec;
						acc_d  = 1'b1;
						if (rem_dec == '0) begin
							recv_d = 1'b0;
							fs_d   = fs_inc;
							if (fs_inc >= fpb_q) begin
								pubf_d  = fs_inc;
								pubw_d  = PUBW_W'(off_inc);
								ready_d = 1'b1;
								coll_d  = 1'b0;
							end
						end
					end
				end
				FUNC_ACK: begin
					if (cmd.word != '0) begin
						if (ready_q) begin
							ready_d = 1'b0;
							coll_d  = 1'b0;
							recv_d  = 1'b0;
							pubf_d  = '0;
							pubw_d  = '0;
							batch_d = batch_q + BATCH_W'(1);
							fs_d    = '0;
							rem_d   = '0;
							off_d   = '0;
							acc_d   = 1'b1;
						end else begin
							err_d = ERR_UNEXP;
						end
					end
				end
				FUNC_READ: begin
					if (addr_ok) begin
						mem_re  = 1'b1;
						rdsel_d = 1'b1;
						acc_d   = 1'b1;
					end else begin
						err_d = ERR_UNEXP;
					end
				end
				default: begin
					err_d = ERR_UNEXP;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_s1 <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q   <= '0;
			fs_q    <= '0;
			rem_q   <= '0;
			recv_q  <= 1'b0;
			ready_q <= 1'b0;
			coll_q  <= 1'b0;
			pubf_q  <= '0;
			pubw_q  <= '0;
			batch_q <= '0;
			fpb_q   <= FPB_RESET;
			done_q  <= 1'b0;
			acc_q   <= 1'b0;
			err_q   <= ERR_NONE;
			rdsel_q <= 1'b0;
		end else begin
			off_q   <= off_d;
			fs_q    <= fs_d;
			rem_q   <= rem_d;
			recv_q  <= recv_d;
			ready_q <= ready_d;
			coll_q  <= coll_d;
			pubf_q  <= pubf_d;
			pubw_q  <= pubw_d;
			batch_q <= batch_d;
			done_q  <= accept;
			acc_q   <= acc_d;
			err_q   <= err_d;
			rdsel_q <= rdsel_d;
			if (cfg_valid && cfg_ready) begin
				fpb_q <= cfg_data;
			end
		end
	end

	// The state registers already hold the state after the item, so the
	// status fields come straight from them during the result cycle.
	assign done                 = done_q;
	assign res.accepted         = acc_q;
	assign res.error_code       = err_q;
	assign res.read_data        = rdsel_q ? rdata_s1 : '0;
	assign res.ready_res        = ready_q;
	assign res.collecting       = coll_q;
	assign res.frames_published = pubf_q;
	assign res.words_published  = pubw_q;
	assign res.batch_id         = batch_q;

endmodule

[rtl/core/mfcb_checker.sv]
// Port-level checks for the multi-frame capture buffer, bound to the top level.
// Depends on mfcb_pkg and multi_frame_capture_buffer.
module mfcb_checker
	import mfcb_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input cmd_t cmd,
	input logic done,
	input res_t res
);

	// A result only follows a command taken on the edge before.
	a_done_follows_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result strobe without a preceding command");

	// A command taken outside reset always yields a result next cycle.
	a_cmd_gets_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done)
		else $error("command taken but no result followed");

	a_accept_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.accepted |-> res.error_code == ERR_NONE)
		else $error("accepted item reports an error");

	// Freezing ends collection; counts are published only while frozen.
	a_frozen_not_collecting: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.ready_res |-> !res.collecting)
		else $error("frozen buffer still reports collecting");

	a_publish_only_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		done && !res.ready_res |-> res.frames_published == '0 && res.words_published == '0)
		else $error("published counts present while not frozen");

endmodule

bind multi_frame_capture_buffer mfcb_checker u_mfcb_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.res    (res)
);

[verif/tb_multi_frame_capture_buffer.sv]
// Self-checking testbench for multi_frame_capture_buffer: a directed script
// followed by random phases, checked against an in-bench frame model or typed-in results.
// Depends on mfcb_pkg and the multi_frame_capture_buffer RTL.
`timescale 1ns / 100ps

module tb_multi_frame_capture_buffer;
	import mfcb_pkg::*;

	localparam int BUFFER_WORDS = BUFFER_WORDS_DEF;
	// Watchdog limit; a run that goes past it is reported as broken.
	localparam int CYCLE_LIMIT = 400000;

	// One row of the directed script. When typed is set, want is the literal
	// result; otherwise the frame model supplies it.
	typedef struct {
		cmd_t beat;
		bit   typed;
		res_t want;
	} script_row_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	cmd_t                cmd;
	logic                done;
	res_t                res;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [FRAMES_W-1:0] cfg_data;

	multi_frame_capture_buffer #(
		.BUFFER_WORDS(BUFFER_WORDS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.res      (res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// Frame model state. It mirrors the block's control registers and keeps
	// its own copy of the frame store.
	logic [WORD_W-1:0]   model_store [0:BUFFER_WORDS-1];
	int                  wr_offset = 0;
	int                  words_left = 0;
	logic [FRAMES_W-1:0] frames_done = '0;
	bit                  in_frame = 1'b0;
	bit                  frozen = 1'b0;
	bit                  collecting_m = 1'b0;
	logic [FRAMES_W-1:0] pub_frames = '0;
	logic [PUBW_W-1:0]   pub_words = '0;
	logic [BATCH_W-1:0]  batch_num = '0;
	logic [FRAMES_W-1:0] batch_size = FPB_RESET;
	// Words below this index have been written at least once, so reads stay under it.
	int                  written_extent = 0;

	res_t        due_results [$];
	res_t        predicted;
	res_t        due;
	int          fault_count = 0;
	int          cycle_count = 0;
	bit          row_typed = 1'b0;
	res_t        row_want = '0;
	bit          fill_pending = 1'b0;
	script_row_t directed_steps [0:24];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic cmd_t mk_cmd(logic [1:0] f, logic [WORD_W-1:0] w,
			logic [RADDR_W-1:0] a);
		cmd_t c;
		c.func = f;
		c.word = w;
		c.read_addr = a;
		return c;
	endfunction

	// A refused item seen straight after reset: every status field is zero.
	function automatic res_t refused(logic [2:0] err);
		res_t r;
		r = '0;
		r.error_code = err;
		return r;
	endfunction

	task automatic store_word(input logic [WORD_W-1:0] v);
		if (wr_offset < BUFFER_WORDS) begin
			model_store[wr_offset] = v;
			wr_offset++;
			if (wr_offset > written_extent)
				written_extent = wr_offset;
		end
	endtask

	// Applies one command beat to the frame model and returns the result the
	// block must show for it.
	task automatic predict_capture(input cmd_t c, output res_t r);
		r = '0;
		case (c.func)
			FUNC_BEGIN: begin
				if (frozen)
					r.error_code = ERR_FROZEN;
				else if (in_frame)
					r.error_code = ERR_UNEXP;
				else if (c.word == '0)
					r.error_code = ERR_EMPTY;
				else if (wr_offset + 1 + int'(c.word) > BUFFER_WORDS)
					r.error_code = ERR_NOROOM;
				else begin
					if (frames_done == '0)
						collecting_m = 1'b1;
					store_word(c.word);
					words_left = int'(c.word);
					in_frame = 1'b1;
					r.accepted = 1'b1;
				end
			end
			FUNC_DATA: begin
				if (!in_frame) begin
					r.error_code = frozen ? ERR_FROZEN : ERR_UNEXP;
				end else begin
					store_word(c.word);
					words_left--;
					r.accepted = 1'b1;
					if (words_left == 0) begin
						in_frame = 1'b0;
						frames_done = frames_done + 1'b1;
						// A batch size of zero freezes after the first frame.
						if (frames_done >= batch_size) begin
							pub_frames = frames_done;
							pub_words = wr_offset[PUBW_W-1:0];
							frozen = 1'b1;
							collecting_m = 1'b0;
						end
					end
				end
			end
			FUNC_ACK: begin
				// An acknowledge of zero is ignored without error.
				if (c.word != '0) begin
					if (frozen) begin
						frozen = 1'b0;
						collecting_m = 1'b0;
						in_frame = 1'b0;
						pub_frames = '0;
						pub_words = '0;
						batch_num = batch_num + 1'b1;
						frames_done = '0;
						words_left = 0;
						wr_offset = 0;
						r.accepted = 1'b1;
					end else begin
						r.error_code = ERR_UNEXP;
					end
				end
			end
			FUNC_READ: begin
				if (int'(c.read_addr) < BUFFER_WORDS) begin
					r.read_data = model_store[c.read_addr];
					r.accepted = 1'b1;
				end else begin
					r.error_code = ERR_UNEXP;
				end
			end
			default: begin
				r.error_code = ERR_UNEXP;
			end
		endcase
		r.ready_res = frozen;
		r.collecting = collecting_m;
		r.frames_published = pub_frames;
		r.words_published = pub_words;
		r.batch_id = batch_num;
	endtask

	task automatic note_fault(input string what, input logic [15:0] want,
			input logic [15:0] got);
		fault_count++;
		if (fault_count <= 10)
			$display("mismatch on %s: expected 0x%0h, got 0x%0h", what, want, got);
	endtask

	task automatic compare_result(input res_t want, input res_t got);
		if (got.accepted !== want.accepted)
			note_fault("accepted", 16'(want.accepted), 16'(got.accepted));
		if (got.error_code !== want.error_code)
			note_fault("error_code", 16'(want.error_code), 16'(got.error_code));
		if (got.read_data !== want.read_data)
			note_fault("read_data", want.read_data, got.read_data);
		if (got.ready_res !== want.ready_res)
			note_fault("ready_res", 16'(want.ready_res), 16'(got.ready_res));
		if (got.collecting !== want.collecting)
			note_fault("collecting", 16'(want.collecting), 16'(got.collecting));
		if (got.frames_published !== want.frames_published)
			note_fault("frames_published", 16'(want.frames_published),
				16'(got.frames_published));
		if (got.words_published !== want.words_published)
			note_fault("words_published", 16'(want.words_published),
				16'(got.words_published));
		if (got.batch_id !== want.batch_id)
			note_fault("batch_id", want.batch_id, got.batch_id);
	endtask

	// Everything is sampled on the rising edge. Inputs only move on the
	// falling edge, so the beat seen here is stable, and the outputs are the
	// values the block held through the cycle that just ended.
	always @(posedge clk) begin : edge_monitor
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else if (arst_n) begin
			// A result that lands in the same cycle as a new command beat is
			// retired first, so the queue never sees them out of order.
			if (done) begin
				if (due_results.size() == 0) begin
					fault_count++;
					if (fault_count <= 10)
						$display("result beat with no command outstanding: 0x%0h", res);
				end else begin
					due = due_results.pop_front();
					compare_result(due, res);
				end
			end
			if (cfg_valid && cfg_ready)
				batch_size = cfg_data;
			if (start && !busy) begin
				predict_capture(cmd, predicted);
				due_results.push_back(row_typed ? row_want : predicted);
			end
		end
	end

	// Presents one command beat, optionally after an idle gap, and returns on
	// the falling edge after the beat was taken. start stays high between
	// back-to-back beats.
	task automatic issue(input cmd_t c, input bit typed, input res_t want,
			input int idle_pct);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		row_typed = typed;
		row_want = want;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	// The batch size may only change while no result is outstanding. Every
	// command yields its result on the next cycle, so a short pause covers it.
	task automatic set_batch_size(input logic [FRAMES_W-1:0] v);
		start <= 1'b0;
		while (due_results.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Picks the next command from the model state. Most beats form legal
	// frame sequences so that batches fill, freeze and get acknowledged; the
	// rest are reads, or are refused or ignored on purpose.
	task automatic pick_item(output cmd_t c);
		int unsigned roll;
		int unsigned len_roll;
		int room;
		int frames_left;
		int max_len;
		int len;
		c.func = FUNC_READ;
		c.word = WORD_W'($urandom);
		c.read_addr = RADDR_W'($urandom);
		roll = $urandom_range(0, 99);
		if (frozen) begin
			if (roll < 55) begin
				c.func = FUNC_ACK;
				if (c.word == '0)
					c.word = 16'd1;
			end else if (roll < 65) begin
				c.func = FUNC_ACK;
				c.word = '0;
			end else if (roll < 75)
				c.func = FUNC_BEGIN;
			else if (roll < 85)
				c.func = FUNC_DATA;
		end else if (in_frame) begin
			if (roll < 85)
				c.func = FUNC_DATA;
			else if (roll < 96)
				c.func = FUNC_BEGIN;
			else if (roll < 98)
				c.func = FUNC_ACK;
		end else if (roll < 60) begin
			c.func = FUNC_BEGIN;
			room = BUFFER_WORDS - 1 - wr_offset;
			frames_left = (batch_size > frames_done) ? int'(batch_size - frames_done) : 1;
			// Keep two words per later frame so the batch can always complete.
			max_len = room - 2 * (frames_left - 1);
			len_roll = $urandom_range(0, 99);
			if (fill_pending && frames_left == 1 && room >= 1) begin
				len = room;
				fill_pending = 1'b0;
			end else if (len_roll < 4)
				len = 0;
			else if (len_roll < 9)
				len = $urandom_range(room + 1, 65535);
			else if (max_len < 1)
				len = 1;
			else if (len_roll < 12 && frames_left == 1)
				len = max_len;
			else if (len_roll < 60)
				len = 1;
			else if (len_roll < 90)
				len = $urandom_range(1, (max_len < 8) ? max_len : 8);
			else
				len = $urandom_range(1, (max_len < 64) ? max_len : 64);
			c.word = len[WORD_W-1:0];
		end else if (roll < 90)
			c.func = FUNC_DATA;
		else if (roll < 100 && roll >= 90)
			c.func = (roll < 95) ? FUNC_ACK : FUNC_READ;
		if (c.func == FUNC_READ) begin
			// Only words that were written at some point are read back.
			if (written_extent == 0) begin
				c.func = FUNC_ACK;
				c.word = '0;
			end else begin
				c.read_addr = RADDR_W'($urandom_range(0, written_extent - 1));
			end
		end
	endtask

	task automatic run_phase(input int idle_pct, input int goal_items);
		cmd_t c;
		for (int k = 0; k < goal_items; k++) begin
			pick_item(c);
			issue(c, 1'b0, '0, idle_pct);
		end
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;

		// Directed script, run with the batch size left at its reset value.
		// The first rows come straight after reset, so their results are
		// typed in; the rest follow the model.
		directed_steps[0]  = '{mk_cmd(FUNC_DATA, 16'hFFFF, '0), 1'b1, refused(ERR_UNEXP)};
		directed_steps[1]  = '{mk_cmd(FUNC_ACK, 16'h0000, '0), 1'b1, refused(ERR_NONE)};
		directed_steps[2]  = '{mk_cmd(FUNC_ACK, 16'hFFFF, '0), 1'b1, refused(ERR_UNEXP)};
		directed_steps[3]  = '{mk_cmd(FUNC_BEGIN, 16'h0000, '0), 1'b1, refused(ERR_EMPTY)};
		directed_steps[4]  = '{mk_cmd(FUNC_BEGIN, 16'hFFFF, '0), 1'b1, refused(ERR_NOROOM)};
		directed_steps[5]  = '{mk_cmd(FUNC_BEGIN, 16'd1024, '0), 1'b1, refused(ERR_NOROOM)};
		directed_steps[6]  = '{mk_cmd(FUNC_BEGIN, 16'd1, '0), 1'b0, '0};
		// A begin inside an open frame is refused and the frame carries on.
		directed_steps[7]  = '{mk_cmd(FUNC_BEGIN, 16'd2, '0), 1'b0, '0};
		directed_steps[8]  = '{mk_cmd(FUNC_DATA, 16'hFFFF, '0), 1'b0, '0};
		directed_steps[9]  = '{mk_cmd(FUNC_BEGIN, 16'd2, '0), 1'b0, '0};
		directed_steps[10] = '{mk_cmd(FUNC_DATA, 16'h0000, '0), 1'b0, '0};
		directed_steps[11] = '{mk_cmd(FUNC_DATA, 16'hAAAA, '0), 1'b0, '0};
		directed_steps[12] = '{mk_cmd(FUNC_BEGIN, 16'd1, '0), 1'b0, '0};
		directed_steps[13] = '{mk_cmd(FUNC_DATA, 16'h5555, '0), 1'b0, '0};
		directed_steps[14] = '{mk_cmd(FUNC_BEGIN, 16'd1, '0), 1'b0, '0};
		// The fourth frame completes the batch and freezes the buffer.
		directed_steps[15] = '{mk_cmd(FUNC_DATA, 16'h1234, '0), 1'b0, '0};
		directed_steps[16] = '{mk_cmd(FUNC_BEGIN, 16'd1, '0), 1'b0, '0};
		directed_steps[17] = '{mk_cmd(FUNC_DATA, 16'h0001, '0), 1'b0, '0};
		directed_steps[18] = '{mk_cmd(FUNC_READ, 16'hFFFF, 10'd0), 1'b0, '0};
		directed_steps[19] = '{mk_cmd(FUNC_READ, 16'h0000, 10'd8), 1'b0, '0};
		directed_steps[20] = '{mk_cmd(FUNC_ACK, 16'h0000, '0), 1'b0, '0};
		directed_steps[21] = '{mk_cmd(FUNC_ACK, 16'h8000, '0), 1'b0, '0};
		// After the acknowledge the old words must still read back.
		directed_steps[22] = '{mk_cmd(FUNC_READ, 16'h0000, 10'd4), 1'b0, '0};
		directed_steps[23] = '{mk_cmd(FUNC_BEGIN, 16'd1, '0), 1'b0, '0};
		directed_steps[24] = '{mk_cmd(FUNC_DATA, 16'hFFFF, '0), 1'b0, '0};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		foreach (directed_steps[i])
			issue(directed_steps[i].beat, directed_steps[i].typed, directed_steps[i].want, 0);

		// Random phases across batch sizes and sender gap rates. The first frame
		// of the first phase runs to the last word of the store.
		set_batch_size(8'd1);
		fill_pending = 1'b1;
		run_phase(0, 400);
		set_batch_size(8'd255);
		run_phase(62, 700);
		set_batch_size(8'd0);
		run_phase(38, 300);
		set_batch_size(8'($urandom_range(2, 16)));
		run_phase(62, 250);
		set_batch_size(FPB_RESET);
		run_phase(0, 150);

		start <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (fault_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
